/* src/hte_pkg.sv */
// shared types and constants for the prefix-code encoder and bit packer
// no dependencies
`default_nettype none

package hte_pkg;

    localparam int STORE_WIDTH = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_BITS   = 8;
    localparam int ACC_W       = STORE_WIDTH + BYTE_BITS - 1;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_MISSING = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENCODE,
        CMD_MISSING,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [STORE_WIDTH-1:0]  code;
        logic [LEN_W-1:0]        len;
    } cmd_t;

endpackage

`default_nettype wire

/* src/hte_front.sv */
// front part: accepts items, owns the code table, turns each encode or flush item into a command
// depends on hte_pkg
`default_nettype none

module hte_front
    import hte_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             mode,
    input  wire logic [7:0]             symbol,
    input  wire logic [STORE_WIDTH-1:0] code_bits,
    input  wire logic [LEN_W-1:0]       code_length,
    input  wire logic                   entry_present,
    output logic                        cmd_valid,
    output cmd_t                        cmd,
    input  wire logic                   cmd_ready
);

    localparam int LenLimit = (MAX_CODE_LEN < STORE_WIDTH) ? MAX_CODE_LEN : STORE_WIDTH;

    logic [STORE_WIDTH-1:0] code_mem [256];
    logic [LEN_W-1:0]       len_mem  [256];
    logic [255:0]           present_reg;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    cmd_kind_t              s1_kind_reg;
    logic [STORE_WIDTH-1:0] rd_code_reg;
    logic [LEN_W-1:0]       rd_len_reg;

    logic                   accept;
    logic [LEN_W-1:0]       ld_len;
    logic [STORE_WIDTH-1:0] ld_mask;
    cmd_kind_t              kind_in;

    assign full   = s1_valid_reg && !cmd_ready;
    assign accept = push && !full;

    // saturate overlong codes and clear the bits above the kept length
    always_comb
    begin
        ld_len = (code_length > LEN_W'(LenLimit)) ? LEN_W'(LenLimit) : code_length;
        if (ld_len >= LEN_W'(STORE_WIDTH))
            ld_mask = '1;
        else
            ld_mask = (STORE_WIDTH'(1) << ld_len[4:0]) - STORE_WIDTH'(1);
    end

    always_comb
    begin
        case (mode)
            MODE_ENCODE: kind_in = present_reg[symbol] ? CMD_ENCODE : CMD_MISSING;
            default:     kind_in = CMD_FLUSH;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = (mode == MODE_ENCODE) || (mode == MODE_FLUSH);
        else if (cmd_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept && mode == MODE_LOAD)
                present_reg[symbol] <= entry_present;
        end
    end

    // table write and registered read share the transfer edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind_in;
            rd_code_reg <= code_mem[symbol];
            rd_len_reg  <= len_mem[symbol];
            if (mode == MODE_LOAD)
            begin
                code_mem[symbol] <= code_bits & ld_mask;
                len_mem[symbol]  <= ld_len;
            end
        end
    end

    assign cmd_valid = s1_valid_reg;
    assign cmd.kind  = s1_kind_reg;
    assign cmd.code  = rd_code_reg;
    assign cmd.len   = rd_len_reg;

endmodule

`default_nettype wire

/* src/hte_cmd_fifo.sv */
// short command queue between the front part and the packer
// depends on hte_pkg
`default_nettype none

module hte_cmd_fifo
    import hte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_take,
    output cmd_t      rd_cmd
);

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    cmd_t              slot_mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW:0]     count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != (PtrW+1)'(Depth));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;
    assign rd_cmd   = slot_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (PtrW+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (PtrW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

/* src/hte_packer.sv */
// back part: bit accumulator that packs codes lsb first and emits bytes
// depends on hte_pkg
`default_nettype none

module hte_packer
    import hte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_take,
    input  wire cmd_t        cmd,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             status,
    output logic             last
);

    logic [ACC_W-1:0] acc_reg,  acc_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             status_reg, status_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             busy;

    assign out_free = !out_valid_reg || pop;
    // a full byte is still in the accumulator
    assign busy     = (total_reg[LEN_W-1:3] != '0);

    always_comb
    begin
        acc_next       = acc_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cmd_take       = 1'b0;

        if (busy)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = acc_reg[7:0];
                status_next    = STATUS_OK;
                last_next      = (total_reg < LEN_W'(2 * BYTE_BITS));
                acc_next       = acc_reg >> BYTE_BITS;
                total_next     = total_reg - LEN_W'(BYTE_BITS);
            end
        end
        else if (cmd_valid && (cmd.kind == CMD_ENCODE || out_free))
        begin
            cmd_take = 1'b1;
            case (cmd.kind)
                CMD_ENCODE:
                begin
                    acc_next   = {{(ACC_W-7){1'b0}}, acc_reg[6:0]}
                               | ({{(BYTE_BITS-1){1'b0}}, cmd.code} << total_reg[2:0]);
                    total_next = {{(LEN_W-3){1'b0}}, total_reg[2:0]} + cmd.len;
                end
                CMD_MISSING:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    status_next    = STATUS_MISSING;
                    last_next      = 1'b1;
                end
                default:
                begin
                    if (total_reg[2:0] != 3'd0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = {1'b0, acc_reg[6:0]};
                        status_next    = STATUS_OK;
                        last_next      = 1'b1;
                    end
                    acc_next   = '0;
                    total_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign status   = status_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

/* src/huffman_table_encoder_packer_top.sv */
// top level of the table-driven prefix-code encoder with lsb-first byte packer
// depends on hte_pkg, hte_front, hte_cmd_fifo, hte_packer
//
//  channel  | handshake        | fields
//  ---------+------------------+---------------------------------------------------
//  input    | push / full      | mode, symbol, code_bits, code_length, entry_present
//  result   | empty / pop      | out_byte, status, last
//
// an item is taken every cycle while the command queue has room
// the packer takes a command only while no full byte waits in the accumulator, and then emits
// the completed bytes one at a time, each as soon as the result register is free
// missing-symbol and flush results are written to the result register as the command is taken
// reset clears the valid bits, the pending bits and all queues; no clearing pass is needed
// a stalled result holds the packer, which then backs up the queue and raises full
`default_nettype none

module huffman_table_encoder_packer_top
    import hte_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             mode,
    input  wire logic [7:0]             symbol,
    input  wire logic [STORE_WIDTH-1:0] code_bits,
    input  wire logic [LEN_W-1:0]       code_length,
    input  wire logic                   entry_present,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  out_byte,
    output logic                        status,
    output logic                        last
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic q_valid;
    logic q_take;
    cmd_t q_cmd;

    hte_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .entry_present (entry_present),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd),
        .cmd_ready     (front_ready)
    );

    hte_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (q_valid),
        .rd_take  (q_take),
        .rd_cmd   (q_cmd)
    );

    hte_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_take  (q_take),
        .cmd       (q_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire

/* tb/tb_huffman_table_encoder_packer_top.sv */
// testbench for the prefix-code encoder and lsb-first byte packer
// depends on hte_pkg and huffman_table_encoder_packer_top; predicts every packed byte
// and missing-symbol result, and checks each result transfer in order
`default_nettype none

module tb_huffman_table_encoder_packer_top;
    import hte_pkg::*;

    localparam int MAX_LEN     = 32;
    localparam int LEN_CAP     = (MAX_LEN < STORE_WIDTH) ? MAX_LEN : STORE_WIDTH;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 20;

    // the unused mode value, which the block ignores
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       stat;
        logic       fin;
    } out_rec_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   push          = 1'b0;
    logic                   full;
    logic [1:0]             mode          = MODE_LOAD;
    logic [7:0]             symbol        = 8'd0;
    logic [STORE_WIDTH-1:0] code_bits     = '0;
    logic [LEN_W-1:0]       code_length   = '0;
    logic                   entry_present = 1'b0;
    logic                   empty;
    logic                   pop           = 1'b0;
    logic [7:0]             out_byte;
    logic                   status;
    logic                   last;

    // predicted table and packer state
    logic [STORE_WIDTH-1:0] tbl_code  [256];
    logic [LEN_W-1:0]       tbl_len   [256];
    bit                     tbl_valid [256];
    logic [6:0]             pend_bits;
    logic [2:0]             pend_cnt;
    out_rec_t               want_q[$];

    logic [7:0]             loaded_syms[$];
    int                     err_count   = 0;
    int                     burst_left  = 0;
    bit                     gaps_on     = 1'b1;
    int                     pop_pct     = 100;
    int                     stall_left  = 0;
    int                     idle_cycles = 0;
    out_rec_t               head_rec;

    huffman_table_encoder_packer_top #(
        .MAX_CODE_LEN (MAX_LEN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .entry_present (entry_present),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .status        (status),
        .last          (last)
    );

    always #5 clk = ~clk;

    task automatic report(input string what);
        err_count++;
        if (err_count <= 40)
            $display("mismatch: %s", what);
    endtask

    // update the predicted state for one accepted item and queue the results it causes
    task automatic predict_item(input logic [1:0] m, input logic [7:0] s,
                                input logic [STORE_WIDTH-1:0] c, input logic [LEN_W-1:0] l,
                                input logic p);
        logic [ACC_W-1:0]       acc;
        int                     total;
        logic [LEN_W-1:0]       eff_len;
        logic [STORE_WIDTH-1:0] eff_code;
        out_rec_t               rec;
        case (m)
            MODE_LOAD:
            begin
                eff_len  = (l > LEN_CAP) ? LEN_W'(LEN_CAP) : l;
                eff_code = c;
                if (eff_len < STORE_WIDTH)
                    eff_code = c & ((STORE_WIDTH'(1) << eff_len) - STORE_WIDTH'(1));
                tbl_code[s]  = eff_code;
                tbl_len[s]   = eff_len;
                tbl_valid[s] = p;
            end
            MODE_ENCODE:
            begin
                if (!tbl_valid[s])
                begin
                    rec.data = 8'd0;
                    rec.stat = STATUS_MISSING;
                    rec.fin  = 1'b1;
                    want_q   = {want_q, rec};
                end
                else
                begin
                    acc   = ACC_W'(pend_bits) | (ACC_W'(tbl_code[s]) << pend_cnt);
                    total = int'(pend_cnt) + int'(tbl_len[s]);
                    while (total >= BYTE_BITS)
                    begin
                        rec.data = acc[7:0];
                        rec.stat = STATUS_OK;
                        rec.fin  = (total - BYTE_BITS) < BYTE_BITS;
                        want_q   = {want_q, rec};
                        acc   = acc >> BYTE_BITS;
                        total = total - BYTE_BITS;
                    end
                    pend_bits = acc[6:0];
                    pend_cnt  = 3'(total);
                end
            end
            MODE_FLUSH:
            begin
                if (pend_cnt != 3'd0)
                begin
                    rec.data = {1'b0, pend_bits};
                    rec.stat = STATUS_OK;
                    rec.fin  = 1'b1;
                    want_q   = {want_q, rec};
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: ;
        endcase
    endtask

    // drive one item and hold it until the transfer; push stays high for a following item
    task automatic send_item(input logic [1:0] m, input logic [7:0] s,
                             input logic [STORE_WIDTH-1:0] c, input logic [LEN_W-1:0] l,
                             input logic p);
        if (gaps_on && burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        mode          <= m;
        symbol        <= s;
        code_bits     <= c;
        code_length   <= l;
        entry_present <= p;
        push          <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_item(m, s, c, l, p);
    endtask

    // stop sending until every predicted result has been popped, then let the block settle
    task automatic wait_drained();
        push <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] rand_code_len();
        int r;
        r = $urandom_range(1, 100);
        if (r <= 4)
            return '0;
        else if (r <= 62)
            return LEN_W'($urandom_range(1, 8));
        else if (r <= 86)
            return LEN_W'($urandom_range(9, 16));
        else if (r <= 96)
            return LEN_W'($urandom_range(17, 32));
        else
            return LEN_W'($urandom_range(33, 63));
    endfunction

    task automatic test_directed();
        // flush with nothing pending, then a symbol never loaded
        send_item(MODE_FLUSH, 8'h00, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'h05, '1, '1, 1'b1);
        send_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1);
        // zero-length code for the single-symbol case
        send_item(MODE_LOAD, 8'hFF, 32'h1234_5678, 6'd0, 1'b1);
        send_item(MODE_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd1, 1'b1);
        // overlong codes saturate
        send_item(MODE_LOAD, 8'h02, 32'h8000_0001, 6'd33, 1'b1);
        send_item(MODE_LOAD, 8'h03, 32'hA5A5_5A5A, 6'd63, 1'b1);
        // bits above the length are dropped
        send_item(MODE_LOAD, 8'h04, 32'hFFFF_FF2A, 6'd7, 1'b1);
        send_item(MODE_LOAD, 8'h80, 32'h0000_0000, 6'd8, 1'b0);
        send_item(MODE_ENCODE, 8'h01, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'h00, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'hFF, '0, '0, 1'b0);
        send_item(MODE_FLUSH, 8'hFF, '1, '1, 1'b1);
        send_item(MODE_FLUSH, 8'h00, '0, '0, 1'b0);
        send_item(MODE_IGNORED, 8'hFF, '1, '1, 1'b1);
        send_item(MODE_ENCODE, 8'h80, '0, '0, 1'b0);
        // a removed entry reads as missing
        send_item(MODE_LOAD, 8'h01, 32'h0000_001F, 6'd5, 1'b0);
        send_item(MODE_ENCODE, 8'h01, '0, '0, 1'b0);
        send_item(MODE_LOAD, 8'h01, 32'h0000_0005, 6'd3, 1'b1);
        send_item(MODE_ENCODE, 8'h01, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'h04, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'h02, '0, '0, 1'b0);
        send_item(MODE_ENCODE, 8'h03, '0, '0, 1'b0);
        send_item(MODE_FLUSH, 8'h00, '0, '0, 1'b0);
        loaded_syms = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
    endtask

    task automatic test_table_load();
        logic [7:0] s;
        for (int i = 0; i < 48; i++)
        begin
            s = 8'($urandom_range(0, 255));
            send_item(MODE_LOAD, s, $urandom, rand_code_len(), $urandom_range(1, 100) <= 90);
            loaded_syms = {loaded_syms, s};
        end
    endtask

    // mostly encodes of loaded symbols, mixed with reloads, flushes and ignored items
    task automatic test_random_stream(input int count, input bit with_gaps);
        int         r;
        logic [7:0] s;
        gaps_on = with_gaps;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(1, 100);
            if ($urandom_range(1, 100) <= 85)
                s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            else
                s = 8'($urandom_range(0, 255));
            if (r <= 72)
                send_item(MODE_ENCODE, s, $urandom, LEN_W'($urandom), 1'($urandom));
            else if (r <= 82)
            begin
                send_item(MODE_LOAD, s, $urandom, rand_code_len(),
                          $urandom_range(1, 100) <= 88);
                loaded_syms = {loaded_syms, s};
            end
            else if (r <= 94)
                send_item(MODE_FLUSH, s, $urandom, LEN_W'($urandom), 1'($urandom));
            else
                send_item(MODE_IGNORED, s, $urandom, LEN_W'($urandom), 1'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    // result side: check each transfer, then pick the next pop on a stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (want_q.size() == 0)
                    report($sformatf("unexpected result byte %02h status %0d last %0d",
                                     out_byte, status, last));
                else
                begin
                    head_rec = want_q.pop_front();
                    if (out_byte !== head_rec.data || status !== head_rec.stat ||
                        last !== head_rec.fin)
                        report($sformatf("got byte %02h status %0d last %0d, want %02h %0d %0d",
                                         out_byte, status, last,
                                         head_rec.data, head_rec.stat, head_rec.fin));
                end
            end
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    pop_pct = 100;
                    2:       pop_pct = 75;
                    3:       pop_pct = 40;
                    default: pop_pct = 10;
                endcase
                stall_left = $urandom_range(4, 40);
            end
            stall_left--;
            pop <= ($urandom_range(1, 100) <= pop_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
            tbl_valid[i] = 1'b0;
        pend_bits = '0;
        pend_cnt  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_load();
        test_random_stream(170, 1'b1);
        // sender holds off until the block has drained
        wait_drained();
        test_random_stream(190, 1'b0);
        send_item(MODE_FLUSH, 8'h00, '0, '0, 1'b0);
        wait_drained();

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/hte_pkg.sv
src/hte_front.sv
src/hte_cmd_fifo.sv
src/hte_packer.sv
src/huffman_table_encoder_packer_top.sv
tb/tb_huffman_table_encoder_packer_top.sv
